// ----- rtl/lfcd_pkg.sv -----
// ----------------------------------------------------------------------------
// lfcd_pkg
// Shared types, codes and the CRC-16 byte step for the length-framed deframer.
// ----------------------------------------------------------------------------
package lfcd_pkg;

  localparam int unsigned LEN_MIN          = 5;
  localparam int unsigned ANGLE_MIN_PLEN   = 16;
  localparam int unsigned WORD_MIN_PLEN    = 4;
  localparam logic [7:0]  CMD_ANGLE        = 8'h05;
  localparam logic [7:0]  CMD_SAMPLES      = 8'h11;
  localparam logic [7:0]  CMD_SCORE        = 8'h12;
  localparam logic [7:0]  ANGLE_TAG        = 8'd3;
  localparam logic [7:0]  ID_HEADING       = 8'd5;
  localparam logic [7:0]  ID_PITCH         = 8'd24;
  localparam logic [7:0]  ID_ROLL          = 8'd25;
  localparam logic [31:0] SCORE_RESET      = 32'hBF80_0000;
  localparam logic [2:0]  REC_LAST         = 3'd4;

  typedef enum logic [2:0] {
    RD_ZERO = 3'd0,
    RD_ONE  = 3'd1,
    RD_NEXT = 3'd2,
    RD_CHI  = 3'd3,
    RD_CLO  = 3'd4
  } rd_sel_t;

  typedef struct packed {
    logic    push;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    len_hi_ld;
    logic    len_lo_ld;
    logic    crc_start;
    logic    crc_step;
    logic    chi_ld;
    logic    drop;
    logic    emit;
  } lfcd_cmd_t;

  typedef struct packed {
    logic count_lt2;
    logic len_bad;
    logic len_short;
    logic crc_last;
    logic crc_ok;
    logic out_free;
  } lfcd_status_t;

  // XMODEM CRC-16 (poly 0x1021, no reflection), one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = {c_in[7:0], c_in[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

// ----- rtl/lfcd_ram.sv -----
// ----------------------------------------------------------------------------
// lfcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/lfcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfcd_ctrl
// Sequencer: byte intake, length check, CRC walk, slide and frame release.
// ----------------------------------------------------------------------------
module lfcd_ctrl
  import lfcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  lfcd_status_t st,
  output lfcd_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b0_0000_0001,
    ST_CHK  = 9'b0_0000_0010,
    ST_L0   = 9'b0_0000_0100,
    ST_L1   = 9'b0_0000_1000,
    ST_EVAL = 9'b0_0001_0000,
    ST_CRC  = 9'b0_0010_0000,
    ST_R1   = 9'b0_0100_0000,
    ST_R2   = 9'b0_1000_0000,
    ST_EMIT = 9'b1_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_ZERO;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.push  = 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (st.count_lt2) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_L0;
        end
      end
      ST_L0: begin
        cmd.len_hi_ld = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_ONE;
        state_nxt     = ST_L1;
      end
      ST_L1: begin
        cmd.len_lo_ld = 1'b1;
        state_nxt     = ST_EVAL;
      end
      ST_EVAL: begin
        if (st.len_bad) begin
          cmd.drop  = 1'b1;
          state_nxt = ST_CHK;
        end else if (st.len_short) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.crc_start = 1'b1;
          cmd.rd_en     = 1'b1;
          state_nxt     = ST_CRC;
        end
      end
      ST_CRC: begin
        cmd.crc_step = 1'b1;
        cmd.rd_en    = 1'b1;
        if (st.crc_last) begin
          cmd.rd_sel = RD_CHI;
          state_nxt  = ST_R1;
        end else begin
          cmd.rd_sel = RD_NEXT;
        end
      end
      ST_R1: begin
        cmd.chi_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CLO;
        state_nxt  = ST_R2;
      end
      ST_R2: begin
        if (st.crc_ok) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.drop  = 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ----- rtl/lfcd_dp.sv -----
// ----------------------------------------------------------------------------
// lfcd_dp
// Datapath: circular frame store, length and CRC registers, decode and result.
// ----------------------------------------------------------------------------
module lfcd_dp
  import lfcd_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [7:0]   in_rx_byte,
  input  lfcd_cmd_t    cmd,
  output lfcd_status_t st,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [7:0]   out_command_id,
  output logic [6:0]   out_payload_length,
  output logic [31:0]  out_heading_bits,
  output logic [31:0]  out_pitch_bits,
  output logic [31:0]  out_roll_bits,
  output logic         out_angles_updated,
  output logic [31:0]  out_calibration_samples,
  output logic [31:0]  out_score_bits,
  output logic         out_score_valid
);

  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);
  localparam logic [AW:0] DEPTH_A = (AW+1)'(FRAME_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_DEPTH);
  localparam logic [15:0] DEPTH_L = 16'(FRAME_DEPTH);

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= DEPTH_A) ? (s - DEPTH_A) : s;
    return t[AW-1:0];
  endfunction

  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [7:0]    len_hi_r, len_lo_r, chi_r;
  logic [15:0]   len_w, plen_w, crc_r;
  logic [AW-1:0] pos_r, rd_off;
  logic [2:0]    rec_ph_r;
  logic [31:0]   rec_r, rec_w, word_r;
  logic [7:0]    cmd_id_r, tag_r;
  logic [31:0]   t_head_r, t_pitch_r, t_roll_r;
  logic [31:0]   heading_r, pitch_r, roll_r, samples_r, score_r;
  logic          score_flag_r, out_valid_r;
  logic [31:0]   heading_nxt, pitch_nxt, roll_nxt, samples_nxt, score_nxt;
  logic          score_flag_nxt, ang_nxt;
  logic          full_w;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;

  assign len_w  = {len_hi_r, len_lo_r};
  assign plen_w = len_w - 16'(LEN_MIN);
  assign full_w = (count_r == DEPTH_C);

  // write address: append behind the held bytes, overwrite oldest when full
  assign we    = cmd.push;
  assign waddr = full_w ? head_r : wrap({1'b0, head_r} + {1'b0, count_r[AW-1:0]});

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_off = '0;
      RD_ONE:  rd_off = AW'(1);
      RD_NEXT: rd_off = pos_r + AW'(1);
      RD_CHI:  rd_off = len_lo_r[AW-1:0] - AW'(2);
      RD_CLO:  rd_off = len_lo_r[AW-1:0] - AW'(1);
      default: rd_off = '0;
    endcase
  end
  assign raddr = wrap({1'b0, head_r} + {1'b0, rd_off});

  lfcd_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_rx_byte),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign st.count_lt2 = (count_r < CW'(2));
  assign st.len_bad   = (len_w < 16'(LEN_MIN)) || (len_w > DEPTH_L) ||
                        (16'(count_r) > len_w);
  assign st.len_short = (16'(count_r) < len_w);
  assign st.crc_last  = (16'(pos_r) == (len_w - 16'd3));
  assign st.crc_ok    = ({chi_r, rdata} == crc_r);
  assign st.out_free  = !out_valid_r || !out_stall;

  assign rec_w = {rec_r[23:0], rdata};

  // commit decoded fields of the accepted frame
  always_comb begin
    heading_nxt    = heading_r;
    pitch_nxt      = pitch_r;
    roll_nxt       = roll_r;
    samples_nxt    = samples_r;
    score_nxt      = score_r;
    score_flag_nxt = score_flag_r;
    ang_nxt        = 1'b0;
    if (cmd_id_r == CMD_ANGLE) begin
      if (plen_w >= 16'(ANGLE_MIN_PLEN) && tag_r == ANGLE_TAG) begin
        heading_nxt = t_head_r;
        pitch_nxt   = t_pitch_r;
        roll_nxt    = t_roll_r;
        ang_nxt     = 1'b1;
      end
    end else if (cmd_id_r == CMD_SAMPLES) begin
      if (plen_w >= 16'(WORD_MIN_PLEN)) begin
        samples_nxt = word_r;
      end
    end else if (cmd_id_r == CMD_SCORE) begin
      if (plen_w >= 16'(WORD_MIN_PLEN)) begin
        score_nxt      = word_r;
        score_flag_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      count_r      <= '0;
      heading_r    <= '0;
      pitch_r      <= '0;
      roll_r       <= '0;
      samples_r    <= '0;
      score_r      <= SCORE_RESET;
      score_flag_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (full_w) begin
          head_r <= wrap({1'b0, head_r} + (AW+1)'(1));
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.drop) begin
        head_r  <= wrap({1'b0, head_r} + (AW+1)'(1));
        count_r <= count_r - CW'(1);
      end
      if (cmd.emit) begin
        count_r      <= '0;
        heading_r    <= heading_nxt;
        pitch_r      <= pitch_nxt;
        roll_r       <= roll_nxt;
        samples_r    <= samples_nxt;
        score_r      <= score_nxt;
        score_flag_r <= score_flag_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_hi_ld) begin
      len_hi_r <= rdata;
    end
    if (cmd.len_lo_ld) begin
      len_lo_r <= rdata;
    end
    if (cmd.chi_ld) begin
      chi_r <= rdata;
    end
    if (cmd.crc_start) begin
      crc_r     <= '0;
      pos_r     <= '0;
      rec_ph_r  <= '0;
      t_head_r  <= heading_r;
      t_pitch_r <= pitch_r;
      t_roll_r  <= roll_r;
    end else if (cmd.crc_step) begin
      crc_r <= crc16_step(crc_r, rdata);
      pos_r <= pos_r + AW'(1);
      if (pos_r == AW'(2)) begin
        cmd_id_r <= rdata;
      end
      if (pos_r == AW'(3)) begin
        tag_r <= rdata;
      end
      if (pos_r >= AW'(3) && pos_r <= AW'(6)) begin
        word_r <= {word_r[23:0], rdata};
      end
      // angle records: id byte plus four value bytes from payload offset one
      if (pos_r >= AW'(4)) begin
        rec_r <= rec_w;
        if (rec_ph_r == REC_LAST) begin
          rec_ph_r <= '0;
          if (rec_r[31:24] == ID_HEADING) begin
            t_head_r <= {rec_r[23:0], rdata};
          end else if (rec_r[31:24] == ID_PITCH) begin
            t_pitch_r <= {rec_r[23:0], rdata};
          end else if (rec_r[31:24] == ID_ROLL) begin
            t_roll_r <= {rec_r[23:0], rdata};
          end
        end else begin
          rec_ph_r <= rec_ph_r + 3'd1;
        end
      end
    end
    if (cmd.emit) begin
      out_command_id          <= cmd_id_r;
      out_payload_length      <= plen_w[6:0];
      out_heading_bits        <= heading_nxt;
      out_pitch_bits          <= pitch_nxt;
      out_roll_bits           <= roll_nxt;
      out_angles_updated      <= ang_nxt;
      out_calibration_samples <= samples_nxt;
      out_score_bits          <= score_nxt;
      out_score_valid         <= score_flag_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/length_framed_crc_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// length_framed_crc_deframer_unit
// Receives serial bytes, finds length-prefixed CRC-16 frames and decodes them.
// ----------------------------------------------------------------------------
// Each request on the in_ channel is one received byte. The byte is appended
// to a circular frame store (one RAM, one read port, registered read), then
// the sequencer resynchronizes: it reads the two length bytes and evaluates
// them, drops the oldest byte when the length is out of range or fewer bytes
// are needed, and once the store holds exactly one frame it walks the RAM
// one byte per cycle for the CRC. A CRC mismatch drops the oldest byte and
// repeats the check on what is left; each slide may walk the whole store
// again. The next byte is accepted only once the sequencer is idle again.
// Decoding of the command payload runs alongside the CRC walk and is only
// committed when the CRC matches. One result request is emitted per accepted
// frame; it waits in an output register, and the next byte is taken while it
// is still stalled.
module length_framed_crc_deframer_unit
  import lfcd_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_command_id,
  output logic [6:0]  out_payload_length,
  output logic [31:0] out_heading_bits,
  output logic [31:0] out_pitch_bits,
  output logic [31:0] out_roll_bits,
  output logic        out_angles_updated,
  output logic [31:0] out_calibration_samples,
  output logic [31:0] out_score_bits,
  output logic        out_score_valid
);

  lfcd_cmd_t    cmd;
  lfcd_status_t st;

  // sequencer: hold off input until the store is resynchronized
  lfcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // store, CRC, decode and result register
  lfcd_dp #(.FRAME_DEPTH(FRAME_DEPTH)) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_rx_byte              (in_rx_byte),
    .cmd                     (cmd),
    .st                      (st),
    .out_stall               (out_stall),
    .out_valid               (out_valid),
    .out_command_id          (out_command_id),
    .out_payload_length      (out_payload_length),
    .out_heading_bits        (out_heading_bits),
    .out_pitch_bits          (out_pitch_bits),
    .out_roll_bits           (out_roll_bits),
    .out_angles_updated      (out_angles_updated),
    .out_calibration_samples (out_calibration_samples),
    .out_score_bits          (out_score_bits),
    .out_score_valid         (out_score_valid)
  );

  // a frame is released only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("frame released while result register busy");

  // an accepted byte always starts a resync pass
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again without resync");

  // a released frame shows up as a result request
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("released frame not presented");

  // store writes never coincide with slides or frame releases
  a_push_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && (cmd.drop || cmd.emit)))
    else $error("store push overlaps slide or release");

endmodule

// ----- sim/lfcd_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcd_frame_checker
// Watches both channels of the deframer, predicts every decoded frame from
// the byte stream and compares each result request with the oldest one due.
// ----------------------------------------------------------------------------
package lfcd_tb_pkg;

  // Bitwise CRC-16/XMODEM, used both to build frames and to check them
  function automatic logic [15:0] xmodem_add(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

module lfcd_frame_checker
  import lfcd_pkg::*;
  import lfcd_tb_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_command_id,
  input  logic [6:0]  out_payload_length,
  input  logic [31:0] out_heading_bits,
  input  logic [31:0] out_pitch_bits,
  input  logic [31:0] out_roll_bits,
  input  logic        out_angles_updated,
  input  logic [31:0] out_calibration_samples,
  input  logic [31:0] out_score_bits,
  input  logic        out_score_valid,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0]  cmd;
    logic [6:0]  plen;
    logic [31:0] heading;
    logic [31:0] pitch;
    logic [31:0] roll;
    logic        ang;
    logic [31:0] samples;
    logic [31:0] score;
    logic        score_ok;
  } frame_result_t;

  logic [7:0]  rx_buf [DEPTH];
  int unsigned rx_cnt;
  logic [31:0] heading_q, pitch_q, roll_q, samples_q, score_q;
  logic        score_ok_q;
  frame_result_t frames_due [$];

  function automatic logic [31:0] word_at(input int unsigned at);
    return {rx_buf[at], rx_buf[at+1], rx_buf[at+2], rx_buf[at+3]};
  endfunction

  task automatic slide_one();
    for (int unsigned i = 1; i < rx_cnt; i++) rx_buf[i-1] = rx_buf[i];
    if (rx_cnt > 0) rx_cnt--;
  endtask

  task automatic decode_frame(input int unsigned len, output logic ang);
    int unsigned plen, k;
    logic [7:0] id;
    plen = len - LEN_MIN;
    ang = 1'b0;
    if (rx_buf[2] == CMD_ANGLE) begin
      if (plen >= ANGLE_MIN_PLEN && rx_buf[3] == ANGLE_TAG) begin
        k = 1;
        while (k + 5 <= plen) begin
          id = rx_buf[3+k];
          if (id == ID_HEADING) heading_q = word_at(4 + k);
          else if (id == ID_PITCH) pitch_q = word_at(4 + k);
          else if (id == ID_ROLL) roll_q = word_at(4 + k);
          k += 5;
        end
        ang = 1'b1;
      end
    end else if (rx_buf[2] == CMD_SAMPLES) begin
      if (plen >= WORD_MIN_PLEN) samples_q = word_at(3);
    end else if (rx_buf[2] == CMD_SCORE) begin
      if (plen >= WORD_MIN_PLEN) begin
        score_q = word_at(3);
        score_ok_q = 1'b1;
      end
    end
  endtask

  // Append one byte and resynchronize; push a result when a frame closes
  task automatic deframe_byte(input logic [7:0] b);
    int unsigned len;
    logic [15:0] crc;
    logic ang;
    frame_result_t r;
    if (rx_cnt >= DEPTH) slide_one();
    rx_buf[rx_cnt] = b;
    rx_cnt++;
    while (rx_cnt >= 2) begin
      len = {rx_buf[0], rx_buf[1]};
      if (len < LEN_MIN || len > DEPTH || rx_cnt > len) begin
        slide_one();
        continue;
      end
      if (rx_cnt < len) break;
      crc = 16'h0000;
      for (int unsigned i = 0; i < len - 2; i++) crc = xmodem_add(crc, rx_buf[i]);
      if (crc != {rx_buf[len-2], rx_buf[len-1]}) begin
        slide_one();
        continue;
      end
      decode_frame(len, ang);
      r.cmd      = rx_buf[2];
      r.plen     = 7'(len - LEN_MIN);
      r.heading  = heading_q;
      r.pitch    = pitch_q;
      r.roll     = roll_q;
      r.ang      = ang;
      r.samples  = samples_q;
      r.score    = score_q;
      r.score_ok = score_ok_q;
      frames_due.push_back(r);
      rx_cnt = 0;
      break;
    end
  endtask

  task automatic compare_frame();
    frame_result_t e;
    frame_result_t a;
    if (frames_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result request, cmd %h", out_command_id);
      return;
    end
    e = frames_due.pop_front();
    a = {out_command_id, out_payload_length, out_heading_bits, out_pitch_bits,
         out_roll_bits, out_angles_updated, out_calibration_samples,
         out_score_bits, out_score_valid};
    if (a !== e) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch: cmd %h/%h plen %0d/%0d ang %b/%b sv %b/%b",
                 e.cmd, a.cmd, e.plen, a.plen, e.ang, a.ang, e.score_ok, a.score_ok);
        $display("  hdg %h/%h pit %h/%h rol %h/%h smp %h/%h scr %h/%h",
                 e.heading, a.heading, e.pitch, a.pitch, e.roll, a.roll,
                 e.samples, a.samples, e.score, a.score);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_cnt     = 0;
      heading_q  = '0;
      pitch_q    = '0;
      roll_q     = '0;
      samples_q  = '0;
      score_q    = SCORE_RESET;
      score_ok_q = 1'b0;
      frames_due.delete();
    end else begin
      if (out_valid && !out_stall) compare_frame();
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
    end
    pending = frames_due.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream stimulus for the length-framed CRC deframer with a verdict.
// ----------------------------------------------------------------------------
// Mostly well-formed frames with random content, mixed with corrupted frames,
// bad length prefixes and noise bytes. The checker beside the block predicts
// and compares; this module only drives traffic, pressure and the watchdog.
module testbench;
  import lfcd_pkg::*;
  import lfcd_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_command_id;
  logic [6:0]  out_payload_length;
  logic [31:0] out_heading_bits;
  logic [31:0] out_pitch_bits;
  logic [31:0] out_roll_bits;
  logic        out_angles_updated;
  logic [31:0] out_calibration_samples;
  logic [31:0] out_score_bits;
  logic        out_score_valid;
  int          fail_count;
  int          pending;

  // idle percentages per side, changed by phase
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_req;
  logic        hold_active;
  int          quiet_cycles;
  int          bytes_sent;

  length_framed_crc_deframer_unit i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_rx_byte, .out_valid, .out_stall,
    .out_command_id, .out_payload_length, .out_heading_bits, .out_pitch_bits,
    .out_roll_bits, .out_angles_updated, .out_calibration_samples,
    .out_score_bits, .out_score_valid
  );

  lfcd_frame_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_rx_byte, .out_valid, .out_stall,
    .out_command_id, .out_payload_length, .out_heading_bits, .out_pitch_bits,
    .out_roll_bits, .out_angles_updated, .out_calibration_samples,
    .out_score_bits, .out_score_valid, .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Receiver: random stall, or a long hold-off while one is active
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_active) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Hold-off length counted here, apart from the stall driver
  initial begin
    hold_req    = 1'b0;
    hold_active = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no request moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until accepted; maybe idle afterwards
  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Frame a command and payload with length prefix and CRC, then send it
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] body [$],
                            input bit corrupt);
    logic [7:0]  f [$];
    logic [15:0] len;
    logic [15:0] crc;
    int unsigned pos;
    len = 16'(body.size() + LEN_MIN);
    f.push_back(len[15:8]);
    f.push_back(len[7:0]);
    f.push_back(cmd);
    foreach (body[i]) f.push_back(body[i]);
    crc = 16'h0000;
    foreach (f[i]) crc = xmodem_add(crc, f[i]);
    f.push_back(crc[15:8]);
    f.push_back(crc[7:0]);
    if (corrupt) begin
      pos = $urandom_range(f.size() - 1);
      f[pos] = f[pos] ^ (8'h01 << $urandom_range(7));
    end
    foreach (f[i]) send_byte(f[i]);
  endtask

  // Build an angle payload: tag byte then records with random ids
  task automatic angle_body(input int unsigned plen, input bit tagged_ok,
                            output logic [7:0] body [$]);
    int unsigned sel;
    body.delete();
    body.push_back(tagged_ok ? ANGLE_TAG : 8'($urandom_range(255)));
    while (body.size() < plen) begin
      if ((body.size() - 1) % 5 == 0) begin
        sel = $urandom_range(3);
        body.push_back(sel == 0 ? ID_HEADING : sel == 1 ? ID_PITCH :
                       sel == 2 ? ID_ROLL : 8'($urandom_range(255)));
      end else begin
        body.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic random_body(input int unsigned plen, output logic [7:0] body [$]);
    body.delete();
    repeat (plen) body.push_back(8'($urandom_range(255)));
  endtask

  // One random frame, sometimes broken or preceded by noise
  task automatic random_frame();
    logic [7:0]  body [$];
    logic [7:0]  cmd;
    int unsigned pick, plen;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
    end
    pick = $urandom_range(9);
    plen = ($urandom_range(19) == 0) ? $urandom_range(123) : $urandom_range(30);
    if (pick < 4) begin
      cmd = CMD_ANGLE;
      if ($urandom_range(9) != 0) plen = $urandom_range(16, 31);
      if (plen == 0) plen = 1;
      angle_body(plen, $urandom_range(9) != 0, body);
    end else begin
      cmd = pick < 6 ? CMD_SAMPLES : pick < 8 ? CMD_SCORE : 8'($urandom_range(255));
      if (pick < 8 && $urandom_range(3) != 0) plen = $urandom_range(4, 8);
      random_body(plen, body);
    end
    send_frame(cmd, body, $urandom_range(7) == 0);
  endtask

  // Drain: stop offering and wait until every due result has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    logic [7:0] body [$];
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = 8'h00;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    bytes_sent    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: minimum frame with unknown command, each command, short payloads
    random_body(0, body);
    send_frame(8'hFF, body, 1'b0);
    random_body(4, body);
    send_frame(CMD_SAMPLES, body, 1'b0);
    random_body(4, body);
    send_frame(CMD_SCORE, body, 1'b0);
    random_body(3, body);
    send_frame(CMD_SCORE, body, 1'b0);
    angle_body(16, 1'b1, body);
    send_frame(CMD_ANGLE, body, 1'b0);
    angle_body(15, 1'b1, body);
    send_frame(CMD_ANGLE, body, 1'b0);
    // bad length prefixes: too short, too long, all ones
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'h00);
    send_byte(8'h81);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // longest frame
    angle_body(123, 1'b1, body);
    send_frame(CMD_ANGLE, body, 1'b0);
    drain();

    // Phase 1: sender idles often, receiver idles most; long hold-off midway
    send_idle_pct = 36;
    recv_idle_pct = 76;
    while (bytes_sent < 650) begin
      random_frame();
      if (bytes_sent > 300 && bytes_sent < 340) hold_req = 1'b1;
    end
    drain();

    // Phase 2: the other way round
    send_idle_pct = 76;
    recv_idle_pct = 36;
    while (bytes_sent < 1300) random_frame();
    drain();

    // Phase 3: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_sent < 1950) random_frame();
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
